[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define TLPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TLPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tlpt_pkg.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform package
// Shared types, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpt_pkg;

    localparam int CW       = 36;
    localparam int ZW       = 34;
    localparam int ATAN_LEN = 24;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam logic [2:0] REG_RANGE_MIN = 3'd0;
    localparam logic [2:0] REG_RANGE_MAX = 3'd1;
    localparam logic [2:0] REG_START     = 3'd2;
    localparam logic [2:0] REG_STEP      = 3'd3;
    localparam logic [2:0] REG_CAL_ROLL  = 3'd4;
    localparam logic [2:0] REG_CAL_PITCH = 3'd5;
    localparam logic [2:0] REG_CAL_YAW   = 3'd6;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [15:0] range;
        logic [15:0] beam;
        logic [15:0] tilt;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [15:0] tilt;
        t_coord      third;
    } t_side;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = 34'sh20000000;
            1:  v = 34'sh12E4051E;
            2:  v = 34'sh09FB385B;
            3:  v = 34'sh051111D4;
            4:  v = 34'sh028B0D43;
            5:  v = 34'sh0145D7E1;
            6:  v = 34'sh00A2F61E;
            7:  v = 34'sh00517C55;
            8:  v = 34'sh0028BE53;
            9:  v = 34'sh00145F2F;
            10: v = 34'sh000A2F98;
            11: v = 34'sh000517CC;
            12: v = 34'sh00028BE6;
            13: v = 34'sh000145F3;
            14: v = 34'sh0000A2FA;
            15: v = 34'sh0000517D;
            16: v = 34'sh000028BE;
            17: v = 34'sh0000145F;
            18: v = 34'sh00000A30;
            19: v = 34'sh00000518;
            20: v = 34'sh0000028C;
            21: v = 34'sh00000146;
            22: v = 34'sh000000A3;
            23: v = 34'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/tilted_lidar_point_transform_core.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform core
// Turns lidar range samples into tilted, calibrated 3-D points.
// ----------------------------------------------------------------------------
// One sample enters per clock and one point leaves per clock while the result
// side pops. A sample's queue entry is written at the edge that accepts it; the
// sample then passes through the five pipelined CORDIC rotators in series and
// the result register. While a point waits unpopped the whole pipeline holds.
// The user must write registers through the APB port only while no samples are
// in flight; the block itself does not enforce this.
`default_nettype none

module tilted_lidar_point_transform_core import tlpt_pkg::*; #(
    parameter int MAX_SAMPLES   = 4096,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] i_range_mm,
    input  wire logic        i_range_finite,
    input  wire logic [11:0] i_sample_index,
    input  wire logic [15:0] i_tilt_angle,
    input  wire logic        i_last_sample,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_point_valid,
    output logic [16:0]      o_x_mm,
    output logic [16:0]      o_y_mm,
    output logic [16:0]      o_z_mm,
    output logic             o_last_point
);

    logic [15:0] r_range_min, r_range_max, r_start, r_step;
    logic [15:0] r_roll, r_pitch, r_yaw;
    logic [2:0]  reg_idx;
    logic        wr;

    t_item  f_item;
    t_item  q_item;
    t_qstat q_stat;
    logic   take;
    logic   out_vld;

    assign reg_idx = paddr[4:2];
    assign wr      = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= 16'd0;
            r_range_max <= 16'hFFFF;
            r_start     <= 16'h8000;
            r_step      <= 16'd182;
            r_roll      <= 16'd0;
            r_pitch     <= 16'd0;
            r_yaw       <= 16'd0;
        end else if (wr) begin
            unique case (reg_idx)
                REG_RANGE_MIN: r_range_min <= pwdata[15:0];
                REG_RANGE_MAX: r_range_max <= pwdata[15:0];
                REG_START:     r_start     <= pwdata[15:0];
                REG_STEP:      r_step      <= pwdata[15:0];
                REG_CAL_ROLL:  r_roll      <= pwdata[15:0];
                REG_CAL_PITCH: r_pitch     <= pwdata[15:0];
                REG_CAL_YAW:   r_yaw       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RANGE_MIN: prdata = {16'b0, r_range_min};
            REG_RANGE_MAX: prdata = {16'b0, r_range_max};
            REG_START:     prdata = {16'b0, r_start};
            REG_STEP:      prdata = {16'b0, r_step};
            REG_CAL_ROLL:  prdata = {16'b0, r_roll};
            REG_CAL_PITCH: prdata = {16'b0, r_pitch};
            REG_CAL_YAW:   prdata = {16'b0, r_yaw};
            default:       prdata = 32'b0;
        endcase
    end

    tlpt_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_finite(i_range_finite), .i_range(i_range_mm), .i_index(i_sample_index),
        .i_tilt(i_tilt_angle), .i_last(i_last_sample), .i_range_min(r_range_min),
        .i_range_max(r_range_max), .i_start(r_start), .i_step(r_step), .o_item(f_item)
    );

    tlpt_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(push && !q_stat.full), .i_item(f_item),
        .i_rd(take), .o_item(q_item), .o_stat(q_stat)
    );

    tlpt_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk, .i_rst_n, .i_vld(!q_stat.empty), .i_item(q_item), .o_take(take),
        .i_roll(r_roll), .i_pitch(r_pitch), .i_yaw(r_yaw), .i_pop(pop),
        .o_vld(out_vld), .o_point_valid, .o_x(o_x_mm), .o_y(o_y_mm), .o_z(o_z_mm),
        .o_last(o_last_point)
    );

    assign full  = q_stat.full;
    assign empty = !out_vld;

endmodule

`default_nettype wire

[rtl/tlpt_front.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform front end
// Checks a sample against the limits and forms its beam angle.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpt_front import tlpt_pkg::*; #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic        i_finite,
    input  wire logic [15:0] i_range,
    input  wire logic [11:0] i_index,
    input  wire logic [15:0] i_tilt,
    input  wire logic        i_last,
    input  wire logic [15:0] i_range_min,
    input  wire logic [15:0] i_range_max,
    input  wire logic [15:0] i_start,
    input  wire logic [15:0] i_step,
    output t_item            o_item
);

    logic [31:0] prod;
    logic        ok;

    always_comb begin
        prod = {20'b0, i_index} * {16'b0, i_step};
        ok = i_finite && (i_range >= i_range_min) && (i_range <= i_range_max)
            && ({20'b0, i_index} < 32'(MAX_SAMPLES));
        o_item.valid = ok;
        o_item.last  = i_last;
        o_item.range = ok ? i_range : 16'b0;
        o_item.beam  = i_start + prod[15:0];
        o_item.tilt  = i_tilt;
    end

endmodule

`default_nettype wire

[rtl/tlpt_queue.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform queue
// Two-entry queue between the front end and the rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpt_queue import tlpt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr,
    input  t_item      i_item,
    input  wire logic  i_rd,
    output t_item      o_item,
    output t_qstat     o_stat
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

endmodule

`default_nettype wire

[rtl/tlpt_rot.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform rotator
// Pipelined gain-corrected CORDIC rotation of one coordinate pair.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpt_rot import tlpt_pkg::*; #(
    parameter int STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  t_coord           i_u,
    input  t_coord           i_v,
    input  wire logic [15:0] i_w,
    input  t_side            i_side,
    output logic             o_vld,
    output t_coord           o_u,
    output t_coord           o_v,
    output t_side            o_side
);

    localparam int NS = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

    logic signed [16:0] w_x;
    logic               neg;
    logic signed [15:0] w_f;
    t_coord             u_f;
    t_coord             v_f;
    logic signed [30:0] gain;

    logic signed [48:0] r_ulo, r_vlo;
    logic signed [49:0] r_uhi, r_vhi;
    logic        [15:0] r_w;
    logic               r_pv;
    t_side              r_ps;

    t_coord             r_a [NS+1];
    t_coord             r_b [NS+1];
    logic signed [ZW-1:0] r_z [NS+1];
    logic               r_sv [NS+1];
    t_side              r_sd [NS+1];

    logic signed [67:0] su;
    logic signed [67:0] sv;

    always_comb begin
        w_x  = {i_w[15], i_w};
        gain = {1'b0, GAIN_Q30};
        neg  = 1'b0;
        w_f  = i_w;
        if (w_x > 17'sd16384) begin
            neg = 1'b1;
            w_f = 16'(w_x - 17'sd32768);
        end else if (w_x < -17'sd16384) begin
            neg = 1'b1;
            w_f = 16'(w_x + 17'sd32768);
        end
        u_f = neg ? -i_u : i_u;
        v_f = neg ? -i_v : i_v;
        su  = (68'(r_uhi) <<< 17) + 68'(r_ulo);
        sv  = (68'(r_vhi) <<< 17) + 68'(r_vlo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_pv    <= i_vld;
            r_sv[0] <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ulo   <= $signed({1'b0, u_f[16:0]}) * gain;
            r_uhi   <= $signed(u_f[35:17]) * gain;
            r_vlo   <= $signed({1'b0, v_f[16:0]}) * gain;
            r_vhi   <= $signed(v_f[35:17]) * gain;
            r_w     <= w_f;
            r_ps    <= i_side;
            r_a[0]  <= CW'(su >>> 30);
            r_b[0]  <= CW'(sv >>> 30);
            r_z[0]  <= {{2{r_w[15]}}, r_w, 16'b0};
            r_sd[0] <= r_ps;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        t_coord da;
        t_coord db;
        assign da = r_b[i] >>> i;
        assign db = r_a[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[i+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[i+1] <= r_sv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_a[i+1] <= r_a[i] - da;
                    r_b[i+1] <= r_b[i] + db;
                    r_z[i+1] <= r_z[i] - atan_turn(i);
                end else begin
                    r_a[i+1] <= r_a[i] + da;
                    r_b[i+1] <= r_b[i] - db;
                    r_z[i+1] <= r_z[i] + atan_turn(i);
                end
                r_sd[i+1] <= r_sd[i];
            end
        end
    end

    assign o_vld  = r_sv[NS];
    assign o_u    = r_a[NS];
    assign o_v    = r_b[NS];
    assign o_side = r_sd[NS];

endmodule

`default_nettype wire

[rtl/tlpt_back.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform back end
// Five chained rotations, rounding to millimetres and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpt_back import tlpt_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  t_item            i_item,
    output logic             o_take,
    input  wire logic [15:0] i_roll,
    input  wire logic [15:0] i_pitch,
    input  wire logic [15:0] i_yaw,
    input  wire logic        i_pop,
    output logic             o_vld,
    output logic             o_point_valid,
    output logic [16:0]      o_x,
    output logic [16:0]      o_y,
    output logic [16:0]      o_z,
    output logic             o_last
);

    logic   en;
    t_coord x0;
    t_side  s0;

    logic   v1, v2, v3, v4, v5;
    t_coord u1, w1, u2, w2, u3, w3, u4, w4, u5, w5;
    t_side  s1, s2, s3, s4, s5;
    t_side  s1n, s2n, s3n, s4n;

    logic        r_vld;
    logic        r_pv;
    logic        r_last;
    logic [16:0] r_x, r_y, r_z;

    function automatic logic [16:0] to_mm(input t_coord q);
        logic signed [CW:0] r;
        r = ($signed({q[CW-1], q}) + (CW+1)'(32768)) >>> 16;
        if (r < -(CW+1)'(65536)) begin
            r = -(CW+1)'(65536);
        end else if (r > (CW+1)'(65535)) begin
            r = (CW+1)'(65535);
        end
        return r[16:0];
    endfunction

    assign en     = !r_vld || i_pop;
    assign o_take = en && i_vld;

    always_comb begin
        x0       = {4'b0, i_item.range, 16'b0};
        s0.valid = i_item.valid;
        s0.last  = i_item.last;
        s0.tilt  = i_item.tilt;
        s0.third = '0;
        s1n = s1; s1n.third = u1;
        s2n = s2; s2n.third = w2;
        s3n = s3; s3n.third = w3;
        s4n = s4; s4n.third = w4;
    end

    tlpt_rot #(.STAGES(CORDIC_STAGES)) u_beam (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(i_vld), .i_u(x0), .i_v('0),
        .i_w(i_item.beam), .i_side(s0), .o_vld(v1), .o_u(u1), .o_v(w1), .o_side(s1)
    );

    tlpt_rot #(.STAGES(CORDIC_STAGES)) u_tilt (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(v1), .i_u(w1), .i_v(s1.third),
        .i_w(s1.tilt), .i_side(s1n), .o_vld(v2), .o_u(u2), .o_v(w2), .o_side(s2)
    );

    tlpt_rot #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(v2), .i_u(s2.third), .i_v(u2),
        .i_w(i_yaw), .i_side(s2n), .o_vld(v3), .o_u(u3), .o_v(w3), .o_side(s3)
    );

    tlpt_rot #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(v3), .i_u(s3.third), .i_v(u3),
        .i_w(i_pitch), .i_side(s3n), .o_vld(v4), .o_u(u4), .o_v(w4), .o_side(s4)
    );

    tlpt_rot #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(v4), .i_u(s4.third), .i_v(u4),
        .i_w(i_roll), .i_side(s4n), .o_vld(v5), .o_u(u5), .o_v(w5), .o_side(s5)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pv   <= s5.valid;
            r_last <= s5.last;
            r_x    <= to_mm(s5.third);
            r_y    <= to_mm(u5);
            r_z    <= to_mm(w5);
        end
    end

    assign o_vld         = r_vld;
    assign o_point_valid = r_pv;
    assign o_x           = r_x;
    assign o_y           = r_y;
    assign o_z           = r_z;
    assign o_last        = r_last;

endmodule

`default_nettype wire

[rtl/tlpt_checker.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tlpt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        pready,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        o_point_valid,
    input wire logic [16:0] o_x_mm,
    input wire logic [16:0] o_y_mm,
    input wire logic [16:0] o_z_mm
);

    `TLPT_ASSERT(a_reject_zero, i_clk, i_rst_n, !empty && !o_point_valid |-> o_x_mm == 17'd0 && o_y_mm == 17'd0 && o_z_mm == 17'd0, "Rejected point carries nonzero coordinates.")
    `TLPT_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty, "Result side not empty after reset.")
    `TLPT_ASSERT_ALWAYS(a_rst_full, i_clk, !i_rst_n |=> !full, "Input side full after reset.")
    `TLPT_ASSERT_ALWAYS(a_pready, i_clk, pready, "APB port not ready.")

endmodule

bind tilted_lidar_point_transform_core tlpt_checker u_tlpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .pready(pready), .full(full), .empty(empty),
    .o_point_valid(o_point_valid), .o_x_mm(o_x_mm), .o_y_mm(o_y_mm), .o_z_mm(o_z_mm)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Tilted lidar point transform testbench
// Drives range samples through the queue-style ports, writes the limit and
// calibration registers over APB between phases, predicts each point with a
// bit-exact CORDIC model and compares every popped point with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tlpt_pkg::*;

    localparam int MAX_SAMPLES   = 4096;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = 5 * (CORDIC_STAGES + 2) + 1;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        valid;
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic        last;
    } t_point;

    typedef struct packed {
        logic [15:0] range;
        logic        finite;
        logic [11:0] index;
        logic [15:0] tilt;
        logic        last;
    } t_sample;

    typedef struct {
        t_sample smp;
        logic    typed;
        t_point  pt;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] i_range_mm = '0;
    logic        i_range_finite = 1'b0;
    logic [11:0] i_sample_index = '0;
    logic [15:0] i_tilt_angle = '0;
    logic        i_last_sample = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_point_valid;
    logic [16:0] o_x_mm, o_y_mm, o_z_mm;
    logic        o_last_point;

    tilted_lidar_point_transform_core #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .i_range_mm(i_range_mm), .i_range_finite(i_range_finite),
        .i_sample_index(i_sample_index), .i_tilt_angle(i_tilt_angle),
        .i_last_sample(i_last_sample),
        .empty(empty), .pop(pop),
        .o_point_valid(o_point_valid), .o_x_mm(o_x_mm), .o_y_mm(o_y_mm),
        .o_z_mm(o_z_mm), .o_last_point(o_last_point)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [15:0] rg_min, rg_max, rg_start, rg_step, rg_roll, rg_pitch, rg_yaw;
    t_point      pending_points[$];
    longint      cycles = 0;
    int          mismatches = 0;
    int          hold_off = 0;
    bit          sending_done = 1'b0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void rotate_pair(inout longint u, inout longint v,
                                        input logic [15:0] ang);
        longint a, b, z, da, db;
        int w;
        w = $signed(ang);
        a = u;
        b = v;
        if (w > 16384) begin
            a = -a; b = -b; w -= 32768;
        end else if (w < -16384) begin
            a = -a; b = -b; w += 32768;
        end
        a = floor_sh(a * longint'(GAIN_Q30), 30);
        b = floor_sh(b * longint'(GAIN_Q30), 30);
        z = longint'(w) * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            da = floor_sh(b, i);
            db = floor_sh(a, i);
            if (z >= 0) begin
                a -= da; b += db; z -= longint'(atan_turn(i));
            end else begin
                a += da; b -= db; z += longint'(atan_turn(i));
            end
        end
        u = a;
        v = b;
    endfunction

    function automatic logic [16:0] round_mm(longint q);
        longint r;
        r = floor_sh(q + 32768, 16);
        if (r < -65536) r = -65536;
        if (r > 65535) r = 65535;
        return r[16:0];
    endfunction

    function automatic t_point transform_sample(t_sample s);
        t_point p;
        longint x, y, z;
        logic [15:0] beam;
        p = '0;
        p.last = s.last;
        p.valid = s.finite && s.range >= rg_min && s.range <= rg_max
                  && int'(s.index) < MAX_SAMPLES;
        if (p.valid) begin
            beam = rg_start + 16'(s.index * rg_step);
            x = longint'(s.range) * 65536;
            y = 0;
            z = 0;
            rotate_pair(x, y, beam);
            rotate_pair(y, z, s.tilt);
            rotate_pair(x, y, rg_yaw);
            rotate_pair(z, x, rg_pitch);
            rotate_pair(y, z, rg_roll);
            p.x = round_mm(x);
            p.y = round_mm(y);
            p.z = round_mm(z);
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= {16'(0), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RANGE_MIN: rg_min = val;
            REG_RANGE_MAX: rg_max = val;
            REG_START:     rg_start = val;
            REG_STEP:      rg_step = val;
            REG_CAL_ROLL:  rg_roll = val;
            REG_CAL_PITCH: rg_pitch = val;
            REG_CAL_YAW:   rg_yaw = val;
            default: ;
        endcase
    endtask

    // Push stays high from one request to the next when there is no gap.
    task automatic send_sample(t_sample s, logic typed, t_point want);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) push <= 1'b0;
        repeat (gap) @(posedge i_clk);
        push <= 1'b1;
        {i_range_mm, i_range_finite, i_sample_index, i_tilt_angle, i_last_sample} <= s;
        do @(posedge i_clk); while (full);
        pending_points.insert(pending_points.size(), typed ? want : transform_sample(s));
    endtask

    task automatic drain;
        push <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample();
        t_sample s;
        s.range  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20000));
        s.finite = ($urandom_range(0, 7) != 0);
        s.index  = 12'($urandom);
        s.tilt   = 16'($urandom);
        s.last   = ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    // Receiver: pops with random waits and checks against the oldest prediction.
    initial begin
        int wait_cycles;
        t_point got, want;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (hold_off > 0) begin
                wait_cycles = hold_off;
                hold_off = 0;
            end
            if (wait_cycles > 0) pop <= 1'b0;
            repeat (wait_cycles) @(posedge i_clk);
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got = '{o_point_valid, o_x_mm, o_y_mm, o_z_mm, o_last_point};
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected point: %p", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Point mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    initial begin
        t_row   rows[$];
        t_point zero_pt;
        logic [15:0] settings[4][7];
        rg_min = 16'd0; rg_max = 16'hFFFF; rg_start = 16'h8000; rg_step = 16'd182;
        rg_roll = '0; rg_pitch = '0; rg_yaw = '0;
        zero_pt = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; invalid samples have an obvious all-zero point.
        rows.insert(rows.size(), '{'{16'd1000, 1'b0, 12'd5, 16'd0, 1'b0}, 1'b1, zero_pt});
        rows.insert(rows.size(), '{'{16'd1000, 1'b0, 12'd5, 16'd0, 1'b1}, 1'b1,
                                   '{1'b0, 17'd0, 17'd0, 17'd0, 1'b1}});
        rows.insert(rows.size(), '{'{16'd0, 1'b1, 12'd0, 16'd0, 1'b0}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'hFFFF, 1'b1, 12'hFFF, 16'h7FFF, 1'b1}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'hFFFF, 1'b1, 12'd0, 16'h8000, 1'b0}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'd5000, 1'b1, 12'd1000, 16'h4000, 1'b0}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'd5000, 1'b1, 12'd3000, 16'hC000, 1'b0}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'd5000, 1'b1, 12'd2000, 16'h4001, 1'b0}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'd5000, 1'b1, 12'd2000, 16'hBFFF, 1'b0}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'hAAAA, 1'b1, 12'hAAA, 16'h5555, 1'b1}, 1'b0, zero_pt});
        rows.insert(rows.size(), '{'{16'h5555, 1'b1, 12'h555, 16'hAAAA, 1'b0}, 1'b0, zero_pt});
        foreach (rows[i]) send_sample(rows[i].smp, rows[i].typed, rows[i].pt);
        drain();

        // Narrow window with samples at and beyond its edges, then inverted limits.
        write_reg(REG_RANGE_MIN, 16'd100);
        write_reg(REG_RANGE_MAX, 16'd200);
        send_sample('{16'd99, 1'b1, 12'd0, 16'd0, 1'b0}, 1'b1, zero_pt);
        send_sample('{16'd201, 1'b1, 12'd0, 16'd0, 1'b0}, 1'b1, zero_pt);
        send_sample('{16'd100, 1'b1, 12'd7, 16'd100, 1'b0}, 1'b0, zero_pt);
        send_sample('{16'd200, 1'b1, 12'd9, 16'd100, 1'b0}, 1'b0, zero_pt);
        drain();
        write_reg(REG_RANGE_MIN, 16'd300);
        send_sample('{16'd250, 1'b1, 12'd1, 16'd0, 1'b1}, 1'b1,
                    '{1'b0, 17'd0, 17'd0, 17'd0, 1'b1});
        drain();

        settings[0] = '{16'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        settings[1] = '{16'd0, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
        settings[2] = '{16'd50, 16'd40000, 16'h0000, 16'h0001, 16'h0123, 16'hFF00, 16'h2000};
        settings[3] = '{16'd0, 16'hFFFF, 16'h8000, 16'd182, 16'h4000, 16'hC000, 16'h4001};
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 7; r++) begin
                if (phase < 4) write_reg(3'(r), settings[phase][r]);
                else write_reg(3'(r), r < 2 ? (r == 0 ? 16'($urandom_range(0, 200))
                                                      : 16'($urandom_range(30000, 65535)))
                                            : 16'($urandom));
            end
            // Long receiver stall in one phase so the input queue fills up.
            if (phase == 2) hold_off = 3 * LATENCY + 200;
            for (int n = 0; n < 180; n++) send_sample(random_sample(), 1'b0, zero_pt);
            drain();
        end

        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
